>>> src/mcdm_pkg.sv
`timescale 1ns / 1ps

package mcdm_pkg;

    // Time constants.
    localparam logic [29:0] NS_PER_SEC = 30'd1_000_000_000;
    localparam logic [19:0] NS_PER_MS  = 20'd1_000_000;

    // Field widths.
    localparam int SEC_W  = 32;
    localparam int NS_W   = 30;
    localparam int TB_W   = 31;
    localparam int PTS_W  = 48;
    localparam int OUT_W  = 64;
    localparam int CFG_W  = 32;

    // The scaled timestamp magnitude is at most 2^47 * 1000, which fits 57 bits.
    localparam int DIV_BITS  = 57;
    localparam int DIV_CNT_W = 6;

    // The serial multiplier walks the numerator one bit per cycle.
    localparam int MUL_STEPS = TB_W;
    localparam int MUL_CNT_W = 5;

    // The nanosecond-to-millisecond quotient is below 1000: ten quotient bits.
    localparam int NS_STEPS  = 10;
    localparam int NS_CNT_W  = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START_SECONDS     = 2'd0;
    localparam logic [1:0] CFG_START_NANOSECONDS = 2'd1;
    localparam logic [1:0] CFG_TIME_BASE_NUM     = 2'd2;
    localparam logic [1:0] CFG_TIME_BASE_DEN     = 2'd3;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DIV,
        ST_MUL,
        ST_SIGN,
        ST_DIFF,
        ST_EMIT
    } mcdm_state_t;

endpackage

>>> src/mcdm_div.sv
`timescale 1ns / 1ps

module mcdm_div
    import mcdm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] dividend,
    input  logic [TB_W-1:0]     divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quotient
);

    logic                 run_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TB_W-1:0]      rem_reg;
    logic [TB_W-1:0]      rem_next;
    logic [DIV_BITS-1:0]  quo_reg;
    logic [DIV_BITS-1:0]  quo_next;
    logic [TB_W-1:0]      den_reg;
    logic                 den_zero_reg;
    logic [TB_W:0]        trial;
    logic                 fits;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_BITS-1]};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? TB_W'(trial - {1'b0, den_reg}) : trial[TB_W-1:0];
        quo_next = {quo_reg[DIV_BITS-2:0], fits};
    end

    // Control: run for one step per quotient bit, then pulse done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient register shifts dividend bits out and quotient bits in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg      <= '0;
            quo_reg      <= dividend;
            den_reg      <= divisor;
            den_zero_reg <= (divisor == '0);
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    // A zero divisor gives a zero quotient.
    assign quotient = den_zero_reg ? '0 : quo_reg;

endmodule

>>> src/mcdm_mul.sv
`timescale 1ns / 1ps

module mcdm_mul
    import mcdm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIV_BITS-1:0] multiplicand,
    input  logic [TB_W-1:0]     multiplier,
    output logic                done,
    output logic [OUT_W-1:0]    product
);

    logic                 run_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [OUT_W-1:0]     mcand_reg;
    logic [TB_W-1:0]      mplier_reg;
    logic [OUT_W-1:0]     acc_reg;

    // Control: one step per multiplier bit, then pulse done.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-add: the multiplicand moves left, the multiplier right; the sum wraps at 64 bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= OUT_W'(multiplicand);
            mplier_reg <= multiplier;
            acc_reg    <= '0;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[OUT_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[TB_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

>>> src/media_clock_drift_monitor_unit.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | now_seconds, now_nanoseconds, pts, reset_request
// out     | output    | out_valid / out_stall| media_ms, clock_ms, drift_ms
// cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One beat is processed at a time, from acceptance to result, through the sequencer steps:
// capture, normalization, scaling, the serial divider (one quotient bit per step), the serial
// multiplier (one numerator bit per step), then the sign, difference and emit steps.
// A new beat is accepted once the previous result sits in the output register.
// Reset clears the sequencer, the media offset and the configuration to its defaults.
// A stalled output holds its beat; the last step waits until the output register is free.
`timescale 1ns / 1ps

module media_clock_drift_monitor_unit
    import mcdm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SEC_W-1:0]        now_seconds,
    input  logic [NS_W-1:0]         now_nanoseconds,
    input  logic signed [PTS_W-1:0] pts,
    input  logic                    reset_request,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] media_ms,
    output logic signed [OUT_W-1:0] clock_ms,
    output logic signed [OUT_W-1:0] drift_ms
);

    // Configuration registers.
    logic [SEC_W-1:0] start_seconds_reg;
    logic [NS_W-1:0]  start_nanoseconds_reg;
    logic [TB_W-1:0]  time_base_num_reg;
    logic [TB_W-1:0]  time_base_den_reg;

    // Sequencer.
    mcdm_state_t state_reg;
    mcdm_state_t state_next;
    logic        in_accept;
    logic        out_free;
    logic        div_start;
    logic        mul_start;
    logic        emit;

    // Captured and normalized beat.
    logic [SEC_W:0]       now_sec_reg;
    logic [NS_W-1:0]      now_ns_reg;
    logic [SEC_W:0]       st_sec_reg;
    logic [NS_W-1:0]      st_ns_reg;
    logic [PTS_W-1:0]     pts_reg;
    logic [PTS_W-1:0]     mag_reg;
    logic                 neg_reg;
    logic                 req_reg;

    // Clock path.
    logic [SEC_W+2:0]     sec_diff_reg;
    logic [44:0]          sec_ms_reg;
    logic [19:0]          ns_rem_reg;
    logic [NS_STEPS-1:0]  ns_low_reg;
    logic [NS_CNT_W-1:0]  ns_cnt_reg;

    // Media path and result.
    logic [OUT_W-1:0]     media_reg;
    logic [OUT_W-1:0]     clock_reg;
    logic [OUT_W-1:0]     mc_reg;
    logic [OUT_W-1:0]     rm_reg;
    logic [OUT_W-1:0]     offset_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     media_ms_reg;
    logic [OUT_W-1:0]     clock_ms_reg;
    logic [OUT_W-1:0]     drift_ms_reg;

    // Combinational helpers.
    logic                 now_ge;
    logic                 st_ge;
    logic                 ns_borrow;
    logic [NS_W-1:0]      ns_diff;
    logic [57:0]          mag_wide;
    logic [57:0]          scaled_wide;
    logic [44:0]          sec_wide;
    logic [20:0]          ns_trial;
    logic                 ns_fits;
    logic [DIV_BITS-1:0]  quotient;
    logic                 div_done;
    logic [OUT_W-1:0]     product;
    logic                 mul_done;
    logic                 latch_offset;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seconds_reg     <= '0;
            start_nanoseconds_reg <= '0;
            time_base_num_reg     <= TB_W'(1);
            time_base_den_reg     <= TB_W'(48000);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START_SECONDS:     start_seconds_reg     <= cfg_data[SEC_W-1:0];
                CFG_START_NANOSECONDS: start_nanoseconds_reg <= cfg_data[NS_W-1:0];
                CFG_TIME_BASE_NUM:     time_base_num_reg     <= cfg_data[TB_W-1:0];
                CFG_TIME_BASE_DEN:     time_base_den_reg     <= cfg_data[TB_W-1:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and sequencer outputs.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        mul_start  = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Normalization, borrow and constant scaling.
    always_comb
    begin
        now_ge      = (now_ns_reg >= NS_PER_SEC);
        st_ge       = (start_nanoseconds_reg >= NS_PER_SEC);
        ns_borrow   = (now_ns_reg < st_ns_reg);
        ns_diff     = ns_borrow
                      ? NS_W'({1'b0, now_ns_reg} + {1'b0, NS_PER_SEC} - {1'b0, st_ns_reg})
                      : NS_W'(now_ns_reg - st_ns_reg);
        mag_wide    = {10'b0, mag_reg};
        scaled_wide = (mag_wide << 10) - (mag_wide << 4) - (mag_wide << 3);
        sec_wide    = {{10{sec_diff_reg[SEC_W+2]}}, sec_diff_reg};
        ns_trial    = {ns_rem_reg, ns_low_reg[NS_STEPS-1]};
        ns_fits     = (ns_trial >= {1'b0, NS_PER_MS});
    end

    // Serial nanosecond-to-millisecond division, control part.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_cnt_reg <= '0;
        end
        else if (state_reg == ST_SCALE)
        begin
            ns_cnt_reg <= '0;
        end
        else if (state_reg == ST_DIV && ns_cnt_reg != NS_CNT_W'(NS_STEPS))
        begin
            ns_cnt_reg <= ns_cnt_reg + 1'b1;
        end
    end

    // Beat datapath through the sequencer steps.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            now_sec_reg <= {1'b0, now_seconds};
            now_ns_reg  <= now_nanoseconds;
            pts_reg     <= pts;
            req_reg     <= reset_request;
        end

        if (state_reg == ST_PREP)
        begin
            now_sec_reg <= now_sec_reg + (SEC_W + 1)'(now_ge);
            now_ns_reg  <= now_ge ? NS_W'(now_ns_reg - NS_PER_SEC) : now_ns_reg;
            st_sec_reg  <= {1'b0, start_seconds_reg} + (SEC_W + 1)'(st_ge);
            st_ns_reg   <= st_ge ? NS_W'(start_nanoseconds_reg - NS_PER_SEC)
                                 : start_nanoseconds_reg;
            neg_reg     <= pts_reg[PTS_W-1];
            mag_reg     <= pts_reg[PTS_W-1] ? PTS_W'(~pts_reg + 1'b1) : pts_reg;
        end

        // Elapsed seconds; the nanosecond quotient starts from the top twenty bits,
        // which are already below one million.
        if (state_reg == ST_SCALE)
        begin
            sec_diff_reg <= {2'b0, now_sec_reg} - {2'b0, st_sec_reg}
                            - (SEC_W + 3)'(ns_borrow);
            ns_rem_reg   <= ns_diff[NS_W-1:NS_STEPS];
            ns_low_reg   <= ns_diff[NS_STEPS-1:0];
        end

        if (state_reg == ST_DIV)
        begin
            sec_ms_reg <= (sec_wide << 10) - (sec_wide << 4) - (sec_wide << 3);
            if (ns_cnt_reg != NS_CNT_W'(NS_STEPS))
            begin
                ns_rem_reg <= ns_fits ? 20'(ns_trial - {1'b0, NS_PER_MS})
                                      : ns_trial[19:0];
                ns_low_reg <= {ns_low_reg[NS_STEPS-2:0], ns_fits};
            end
        end

        if (state_reg == ST_SIGN)
        begin
            media_reg <= neg_reg ? (~product + 1'b1) : product;
            clock_reg <= {{(OUT_W - 45){sec_ms_reg[44]}}, sec_ms_reg}
                         + OUT_W'(ns_low_reg);
        end

        if (state_reg == ST_DIFF)
        begin
            mc_reg <= media_reg - clock_reg;
            rm_reg <= media_reg - offset_reg;
        end
    end

    // A zero offset or a reset request relatches the offset.
    assign latch_offset = (offset_reg == '0) || req_reg;

    // Media offset and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                if (latch_offset)
                begin
                    offset_reg <= mc_reg;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output register. A freshly latched offset makes media equal clock and the drift zero.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            media_ms_reg <= latch_offset ? clock_reg : rm_reg;
            clock_ms_reg <= clock_reg;
            drift_ms_reg <= latch_offset ? '0 : (rm_reg - clock_reg);
        end
    end

    mcdm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled_wide[DIV_BITS-1:0]),
        .divisor  (time_base_den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    mcdm_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (quotient),
        .multiplier   (time_base_num_reg),
        .done         (mul_done),
        .product      (product)
    );

    assign out_valid = out_valid_reg;
    assign media_ms  = media_ms_reg;
    assign clock_ms  = clock_ms_reg;
    assign drift_ms  = drift_ms_reg;

endmodule

>>> src/mcdm_checker.sv
`timescale 1ns / 1ps

module mcdm_checker
    import mcdm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [OUT_W-1:0] media_ms,
    input logic signed [OUT_W-1:0] clock_ms,
    input logic signed [OUT_W-1:0] drift_ms
);

    // A beat taken in keeps the input side closed on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a beat is still in work");

    // No result can appear right after a beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

    // The drift is always the media time less the clock time.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> drift_ms == media_ms - clock_ms)
    else $error("drift does not match media minus clock");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(media_ms)
                                   && $stable(clock_ms) && $stable(drift_ms))
    else $error("stalled result beat changed");

endmodule

bind media_clock_drift_monitor_unit mcdm_checker u_mcdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .media_ms  (media_ms),
    .clock_ms  (clock_ms),
    .drift_ms  (drift_ms)
);

>>> bench/media_clock_drift_monitor_unit_tb.sv
`timescale 1ns / 1ps

module media_clock_drift_monitor_unit_tb;
    import mcdm_pkg::*;

    localparam logic [63:0] NS_IN_SEC    = 64'd1_000_000_000;
    localparam logic [63:0] NS_IN_MS     = 64'd1_000_000;
    localparam logic [63:0] MS_IN_SEC    = 64'd1000;
    localparam int          RANDOM_BEATS = 1030;
    localparam int          REPORT_LIMIT = 10;

    // One result beat: media time, wall-clock time and their difference.
    typedef struct packed {
        logic [OUT_W-1:0] media;
        logic [OUT_W-1:0] clock;
        logic [OUT_W-1:0] drift;
    } drift_result_t;

    // One packet event as presented on the input channel.
    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  ns;
        logic [PTS_W-1:0] pts;
        logic             rst_req;
    } packet_t;

    // Drift predictor plus the queue of results still owed by the block.
    class drift_scoreboard;
        logic [63:0]   start_sec;
        logic [63:0]   start_ns;
        logic [63:0]   rate_num;
        logic [63:0]   rate_den;
        logic [63:0]   media_offset;
        drift_result_t owed_q[$];
        int unsigned   beats;
        int unsigned   checked;
        int unsigned   relatches;
        int unsigned   fails;

        function new();
            start_sec    = 64'd0;
            start_ns     = 64'd0;
            rate_num     = 64'd1;
            rate_den     = 64'd48000;
            media_offset = 64'd0;
            beats        = 0;
            checked      = 0;
            relatches    = 0;
            fails        = 0;
        endfunction

        // Mirror a register write, keeping only the bits the register holds.
        function void apply_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_START_SECONDS:     start_sec = {32'd0, data[31:0]};
                CFG_START_NANOSECONDS: start_ns  = {34'd0, data[29:0]};
                CFG_TIME_BASE_NUM:     rate_num  = {33'd0, data[30:0]};
                CFG_TIME_BASE_DEN:     rate_den  = {33'd0, data[30:0]};
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted input beat and queue it.
        function void note_beat(input packet_t p);
            logic [63:0]   sec_now;
            logic [63:0]   ns_now;
            logic [63:0]   sec_ref;
            logic [63:0]   ns_ref;
            logic [63:0]   sec_el;
            logic [63:0]   ns_el;
            logic [63:0]   clock_el;
            logic [63:0]   media_raw;
            logic [63:0]   rel;
            longint        scaled;
            longint        quot;
            drift_result_t r;

            sec_now = {32'd0, p.sec};
            ns_now  = {34'd0, p.ns};
            sec_ref = start_sec;
            ns_ref  = start_ns;

            // Carry a full second out of either nanosecond value.
            if (ns_now >= NS_IN_SEC)
            begin
                sec_now = sec_now + 64'd1;
                ns_now  = ns_now - NS_IN_SEC;
            end
            if (ns_ref >= NS_IN_SEC)
            begin
                sec_ref = sec_ref + 64'd1;
                ns_ref  = ns_ref - NS_IN_SEC;
            end

            // Elapsed wall-clock time, borrowing a second when needed.
            sec_el = sec_now - sec_ref;
            if (ns_now < ns_ref)
            begin
                sec_el = sec_el - 64'd1;
                ns_el  = ns_now + NS_IN_SEC - ns_ref;
            end
            else
            begin
                ns_el = ns_now - ns_ref;
            end
            clock_el = sec_el * MS_IN_SEC + ns_el / NS_IN_MS;

            // Media time: signed division truncating toward zero, then the numerator.
            scaled = longint'($signed(p.pts)) * 1000;
            if (rate_den == 64'd0)
                quot = 0;
            else
                quot = scaled / longint'(rate_den);
            media_raw = rate_num * quot;

            // Relatch the offset when it is zero or a relatch is requested.
            if (media_offset == 64'd0 || p.rst_req)
            begin
                media_offset = media_raw - clock_el;
                relatches++;
            end
            rel = media_raw - media_offset;

            r.media = rel;
            r.clock = clock_el;
            r.drift = rel - clock_el;
            owed_q.push_back(r);
            beats++;
        endfunction

        // Compare one result beat with the oldest owed result.
        function void check_result(input logic [63:0] m, input logic [63:0] c,
                                   input logic [63:0] d);
            drift_result_t want;

            checked++;
            if (owed_q.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                    $display("ERROR: result %0d arrived with none owed: %s %0d %s %0d %s %0d",
                             checked, "media", $signed(m), "clock", $signed(c),
                             "drift", $signed(d));
                return;
            end
            want = owed_q.pop_front();
            if (m !== want.media || c !== want.clock || d !== want.drift)
            begin
                fails++;
                if (fails <= REPORT_LIMIT)
                begin
                    $display("ERROR: result %0d mismatch", checked);
                    $display("  media exp %0d got %0d", $signed(want.media), $signed(m));
                    $display("  clock exp %0d got %0d", $signed(want.clock), $signed(c));
                    $display("  drift exp %0d got %0d", $signed(want.drift), $signed(d));
                end
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [1:0]              cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [SEC_W-1:0]        now_seconds;
    logic [NS_W-1:0]         now_nanoseconds;
    logic signed [PTS_W-1:0] pts;
    logic                    reset_request;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [OUT_W-1:0] media_ms;
    logic signed [OUT_W-1:0] clock_ms;
    logic signed [OUT_W-1:0] drift_ms;

    drift_scoreboard drift_sb;
    int unsigned     settings_used;
    logic            no_gaps;

    media_clock_drift_monitor_unit i_dut (.*);

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(40, 200);
    endfunction

    function automatic packet_t packet(input logic [31:0] s, input logic [29:0] ns,
                                       input logic [47:0] p, input logic r);
        packet_t b;
        b.sec     = s;
        b.ns      = ns;
        b.pts     = p;
        b.rst_req = r;
        return b;
    endfunction

    // One register write, taken at the next rising edge.
    task automatic write_cfg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        drift_sb.apply_cfg(idx, data);
    endtask

    task automatic set_timing(input logic [31:0] s, input logic [31:0] ns,
                              input logic [31:0] num, input logic [31:0] den);
        write_cfg(CFG_START_SECONDS, s);
        write_cfg(CFG_START_NANOSECONDS, ns);
        write_cfg(CFG_TIME_BASE_NUM, num);
        write_cfg(CFG_TIME_BASE_DEN, den);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Present one beat, hold it until accepted, then idle for the given gap.
    task automatic send_beat(input packet_t p, input int unsigned gap);
        in_valid        <= 1'b1;
        now_seconds     <= p.sec;
        now_nanoseconds <= p.ns;
        pts             <= p.pts;
        reset_request   <= p.rst_req;
        @(negedge clk);
        while (in_stall)
            @(negedge clk);
        @(posedge clk);
        drift_sb.note_beat(p);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (drift_sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Pick a timing setting, leaning toward the extremes.
    task automatic random_timing();
        logic [31:0] s;
        logic [31:0] ns;
        logic [31:0] num;
        logic [31:0] den;
        int unsigned r;

        case ($urandom_range(0, 3))
            0:       s = 32'd0;
            1:       s = 32'hFFFF_FFFF;
            default: s = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       ns = 32'd0;
            1:       ns = 32'd999_999_999;
            2:       ns = 32'h3FFF_FFFF;
            3:       ns = $urandom_range(1_000_000_000, 32'h3FFF_FFFF);
            default: ns = $urandom_range(0, 999_999_999);
        endcase
        r = $urandom_range(0, 19);
        if (r == 0)
            num = 32'd0;
        else if (r < 6)
            num = 32'd1;
        else if (r < 8)
            num = 32'h7FFF_FFFF;
        else if (r < 13)
            num = $urandom_range(1, 1001);
        else
            num = $urandom;
        r = $urandom_range(0, 19);
        if (r == 0)
            den = 32'd0;
        else if (r == 1)
            den = 32'd1;
        else if (r < 5)
            den = 32'd48000;
        else if (r < 7)
            den = 32'd90000;
        else if (r == 7)
            den = 32'd44100;
        else if (r < 10)
            den = 32'h7FFF_FFFF;
        else if (r < 14)
            den = $urandom_range(1, 100000);
        else
            den = $urandom;
        set_timing(s, ns, num, den);
    endtask

    // Mostly a well-formed packet stream with random pacing, some noise beats.
    task automatic run_random_phase(input int unsigned count);
        packet_t     p;
        logic [31:0] stream_sec;
        logic [29:0] stream_ns;
        logic [47:0] stream_pts;
        logic [63:0] ns_acc;
        logic [63:0] pts_step;
        logic [63:0] num_nz;
        int unsigned dt;

        stream_sec = drift_sb.start_sec[31:0] + 32'($urandom_range(0, 5));
        stream_ns  = 30'($urandom_range(0, 999_999_999));
        if ($urandom_range(0, 3) == 0)
            stream_pts = 48'({$urandom, $urandom});
        else
            stream_pts = 48'($urandom_range(0, 1 << 20));
        num_nz = (drift_sb.rate_num == 64'd0) ? 64'd1 : drift_sb.rate_num;

        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // Next packet of the stream, 1 to 40 milliseconds later.
                dt     = $urandom_range(1, 40);
                ns_acc = {34'd0, stream_ns} + 64'(dt) * NS_IN_MS;
                if (ns_acc >= NS_IN_SEC)
                begin
                    stream_sec = stream_sec + 32'd1;
                    ns_acc     = ns_acc - NS_IN_SEC;
                end
                stream_ns  = ns_acc[29:0];
                pts_step   = (64'(dt) * drift_sb.rate_den) / (MS_IN_SEC * num_nz);
                stream_pts = stream_pts + pts_step[47:0] + 48'($urandom_range(0, 2));
                p.sec = stream_sec;
                p.ns  = stream_ns;
                p.pts = stream_pts;
                // Same instant written with an unnormalized nanosecond count.
                if ($urandom_range(0, 19) == 0 && stream_ns <= 30'd73_741_823)
                begin
                    p.sec = stream_sec - 32'd1;
                    p.ns  = stream_ns + 30'd1_000_000_000;
                end
            end
            else
            begin
                p.sec = $urandom;
                if ($urandom_range(0, 3) == 0)
                    p.ns = 30'($urandom);
                else
                    p.ns = 30'($urandom_range(0, 999_999_999));
                p.pts = 48'({$urandom, $urandom});
            end
            p.rst_req = ($urandom_range(0, 15) == 0);
            send_beat(p, no_gaps ? 0 : pick_gap());
            if ($urandom_range(0, 40) == 0)
                drain_results();
        end
    endtask

    // Result side stall pattern, with occasional long free-running stretches.
    initial
    begin
        int unsigned hold;
        out_stall <= 1'b0;
        wait (rst_n);
        forever
        begin
            hold = pick_gap();
            if ($urandom_range(0, 49) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(500, 2000)) @(posedge clk);
            end
            else if (hold == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    // Result beats are sampled mid-cycle; each one is taken at the next rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && !out_stall)
                drift_sb.check_result(media_ms, clock_ms, drift_ms);
        end
    end

    // Main sequence: reset, directed beats, then random phases.
    initial
    begin
        int unsigned random_sent;
        int unsigned n;

        drift_sb        = new();
        settings_used   = 0;
        random_sent     = 0;
        no_gaps         = 1'b0;
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= CFG_START_SECONDS;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        now_seconds     <= '0;
        now_nanoseconds <= '0;
        pts             <= '0;
        reset_request   <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default time base: zero offset relatch, field extremes, truncation toward zero.
        set_timing(32'd0, 32'd0, 32'd1, 32'd48000);
        send_beat(packet(32'd0, 30'd0, 48'd0, 1'b0), pick_gap());
        send_beat(packet(32'd0, 30'd500_000_000, 48'd48000, 1'b0), pick_gap());
        send_beat(packet(32'd1, 30'd0, 48'd96000, 1'b0), pick_gap());
        send_beat(packet(32'hFFFF_FFFF, 30'd999_999_999, 48'h7FFF_FFFF_FFFF, 1'b0), pick_gap());
        send_beat(packet(32'd0, 30'd1_000_000_000, 48'h8000_0000_0000, 1'b1), pick_gap());
        send_beat(packet(32'hFFFF_FFFF, 30'h3FFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0), pick_gap());
        send_beat(packet(32'd7, 30'd999_999, 48'hFFFF_FFFF_FFFF, 1'b1), pick_gap());
        drain_results();

        // Start time at or after the packet time, start nanoseconds past one second.
        set_timing(32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'd3, 32'd1);
        send_beat(packet(32'd0, 30'd0, 48'd1, 1'b0), pick_gap());
        send_beat(packet(32'd10, 30'd999_999_999, 48'hFFFF_FFFF_FFFB, 1'b1), pick_gap());
        send_beat(packet(32'hFFFF_FFFF, 30'h3FFF_FFFF, 48'd100, 1'b0), pick_gap());
        send_beat(packet(32'hFFFF_FFFE, 30'd0, 48'd0, 1'b0), pick_gap());
        drain_results();

        // Zero denominator with the largest numerator.
        set_timing(32'd5, 32'd999_999_999, 32'h7FFF_FFFF, 32'd0);
        send_beat(packet(32'd5, 30'd0, 48'd12345, 1'b1), pick_gap());
        send_beat(packet(32'd6, 30'd999_999_999, 48'h7FFF_FFFF_FFFF, 1'b0), pick_gap());
        send_beat(packet(32'd4, 30'd1_000_000_000, 48'h8000_0000_0000, 1'b0), pick_gap());
        drain_results();

        // Zero numerator.
        set_timing(32'd0, 32'd0, 32'd0, 32'd1);
        send_beat(packet(32'd100, 30'd0, 48'h7FFF_FFFF_FFFF, 1'b0), pick_gap());
        send_beat(packet(32'd200, 30'd0, 48'h8000_0000_0000, 1'b1), pick_gap());
        send_beat(packet(32'd300, 30'd123_456_789, 48'd99, 1'b0), pick_gap());
        drain_results();

        // Products that wrap at 64 bits.
        set_timing(32'd1000, 32'd0, 32'h7FFF_FFFF, 32'd1);
        send_beat(packet(32'd2000, 30'd0, 48'h7FFF_FFFF_FFFF, 1'b1), pick_gap());
        send_beat(packet(32'd2000, 30'd0, 48'h8000_0000_0000, 1'b0), pick_gap());
        send_beat(packet(32'd0, 30'd0, 48'h4000_0000_0000, 1'b0), pick_gap());
        drain_results();

        // Largest denominator: small quotients of both signs.
        set_timing(32'd0, 32'd0, 32'd1, 32'h7FFF_FFFF);
        send_beat(packet(32'd1, 30'd0, 48'hFFFF_FFFF_FFFF, 1'b1), pick_gap());
        send_beat(packet(32'd1, 30'd0, 48'h8000_0000_0000, 1'b0), pick_gap());
        send_beat(packet(32'd1, 30'd0, 48'h7FFF_FFFF_FFFF, 1'b0), pick_gap());

        // Random phases, each with its own timing setting.
        while (random_sent < RANDOM_BEATS)
        begin
            drain_results();
            random_timing();
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(10, 60);
            run_random_phase(n);
            random_sent += n;
        end
        drain_results();
        repeat (200) @(posedge clk);

        $display("Summary: %0d beats sent and %0d results checked over %0d timing settings.",
                 drift_sb.beats, drift_sb.checked, settings_used);
        $display("Summary: %0d offset relatches, %0d mismatches.",
                 drift_sb.relatches, drift_sb.fails);
        if (drift_sb.fails == 0 && drift_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/mcdm_pkg.sv
src/mcdm_div.sv
src/mcdm_mul.sv
src/media_clock_drift_monitor_unit.sv
src/mcdm_checker.sv
bench/media_clock_drift_monitor_unit_tb.sv
